/* rtl/grid_symmetry_canonical_check_core_assert.svh */
// Assertion macros shared by the checkers of the grid symmetry canonical check core.
// No dependencies; include by bare file name where assertions are written.
`ifndef GRID_SYMMETRY_CANONICAL_CHECK_CORE_ASSERT_SVH
`define GRID_SYMMETRY_CANONICAL_CHECK_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define GSCC_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define GSCC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gscc_pkg.sv */
// Shared constants, types and the symmetry table of the grid canonical check.
// No dependencies; used by every RTL module of the block.
package gscc_pkg;

	localparam int IDX_W           = 48;
	localparam int RADIX_W         = 6;
	localparam int CELLS           = 9;
	localparam int IMAGES          = 7;
	localparam int STEPS           = 8;
	localparam int CELLS_PER_DIGIT = IDX_W / STEPS;
	localparam int CHAIN_LEN       = CELLS * CELLS_PER_DIGIT;
	localparam int CELL_IDX_W      = $clog2(CELLS);

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd26;

	typedef logic [RADIX_W-1:0] digit_t;
	typedef digit_t [CELLS-1:0] digits_t;

	// One item as it travels down the divider chain.
	typedef struct packed {
		logic             vld;
		logic [RADIX_W-1:0] rem;
		logic [IDX_W-1:0]   work;
		digits_t            dig;
	} cell_bus_t;

	// Entry [k][i] is the source cell that image k places in cell i.
	localparam logic [CELL_IDX_W-1:0] SYM_SRC [IMAGES][CELLS] = '{
		'{4'd6, 4'd7, 4'd8, 4'd3, 4'd4, 4'd5, 4'd0, 4'd1, 4'd2},
		'{4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0},
		'{4'd2, 4'd1, 4'd0, 4'd5, 4'd4, 4'd3, 4'd8, 4'd7, 4'd6},
		'{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8},
		'{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6},
		'{4'd8, 4'd5, 4'd2, 4'd7, 4'd4, 4'd1, 4'd6, 4'd3, 4'd0},
		'{4'd6, 4'd3, 4'd0, 4'd7, 4'd4, 4'd1, 4'd8, 4'd5, 4'd2}
	};

endpackage

/* rtl/gscc_div_cell.sv */
// One cell of the divider chain: eight restoring long-division steps by the radix.
// Depends on gscc_pkg for the bus type and widths.
module gscc_div_cell #(
	parameter int DIGIT = 0,
	parameter bit LAST  = 1'b0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [gscc_pkg::RADIX_W-1:0]    radix,
	input  gscc_pkg::cell_bus_t             bus_in,
	output gscc_pkg::cell_bus_t             bus_out
);

	gscc_pkg::cell_bus_t       nxt;
	gscc_pkg::cell_bus_t       bus_s1;
	logic                      vld_s1;
	logic [gscc_pkg::RADIX_W:0] trial;
	logic [gscc_pkg::RADIX_W:0] diff;

	// The work word shifts dividend bits out of the top and quotient bits in at the bottom.
	// After six cells the work word holds the quotient and the digit has moved from rem into dig.
	always_comb begin
		nxt   = bus_in;
		trial = '0;
		diff  = '0;
		for (int s = 0; s < gscc_pkg::STEPS; s++) begin
			trial    = {nxt.rem, nxt.work[gscc_pkg::IDX_W-1]};
			diff     = trial - {1'b0, radix};
			nxt.work = {nxt.work[gscc_pkg::IDX_W-2:0], 1'b0};
			if (trial >= {1'b0, radix}) begin
				nxt.rem     = diff[gscc_pkg::RADIX_W-1:0];
				nxt.work[0] = 1'b1;
			end else begin
				nxt.rem = trial[gscc_pkg::RADIX_W-1:0];
			end
		end
		if (LAST) begin
			nxt.dig[DIGIT] = nxt.rem;
			nxt.rem        = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= bus_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		bus_s1 <= nxt;
	end

	always_comb begin
		bus_out     = bus_s1;
		bus_out.vld = vld_s1;
	end

endmodule

/* rtl/gscc_sym_cmp.sv */
// Final stage: range check and comparison of the seven symmetric images.
// Depends on gscc_pkg for the bus type and the symmetry table.
module gscc_sym_cmp (
	input  logic                clk,
	input  logic                arst_n,
	input  gscc_pkg::cell_bus_t bus_in,
	output logic                done,
	output logic                is_canonical,
	output logic                out_of_range
);

	gscc_pkg::digits_t               img [gscc_pkg::IMAGES];
	logic [gscc_pkg::IMAGES-1:0]     less;
	logic                            oor;
	logic                            done_q;
	logic                            is_canonical_q;
	logic                            out_of_range_q;

	// With all digits below the radix, comparing encodings is comparing
	// digit strings from cell eight down, which a plain vector compare does.
	for (genvar k = 0; k < gscc_pkg::IMAGES; k++) begin : g_img
		for (genvar i = 0; i < gscc_pkg::CELLS; i++) begin : g_cell
			assign img[k][i] = bus_in.dig[gscc_pkg::SYM_SRC[k][i]];
		end
		assign less[k] = (img[k] < bus_in.dig);
	end

	assign oor = |bus_in.work;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= bus_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		out_of_range_q <= oor;
		is_canonical_q <= !oor && !(|less);
	end

	assign done         = done_q;
	assign is_canonical = is_canonical_q;
	assign out_of_range = out_of_range_q;

endmodule

/* rtl/grid_symmetry_canonical_check_core.sv */
// Top level of the 3x3 grid symmetry canonical check.
// Depends on gscc_pkg, gscc_div_cell and gscc_sym_cmp.
//
// A board index taken with start is split into nine digits of the configured radix
// and checked against its seven rotated and reflected images. The block takes
// one item every cycle and busy stays low. Every item yields one result, passed
// through 54 registered divider cells, each retiring eight quotient bits of one
// long division by the radix, and one registered compare stage. Results appear
// on is_canonical and out_of_range for the single cycle that done is high; the
// receiver cannot stall them. A radix write takes effect for the item taken in
// the next cycle; every cell reads the register, so write it only while no item
// is in flight. A value of zero acts as radix one.
module grid_symmetry_canonical_check_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [gscc_pkg::IDX_W-1:0]    board_index,
	output logic                          done,
	output logic                          is_canonical,
	output logic                          out_of_range,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gscc_pkg::RADIX_W-1:0]  cfg_data
);

	logic [gscc_pkg::RADIX_W-1:0] radix_cfg_q;
	logic [gscc_pkg::RADIX_W-1:0] radix;
	gscc_pkg::cell_bus_t          chain [gscc_pkg::CHAIN_LEN+1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_cfg_q <= gscc_pkg::RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_cfg_q <= cfg_data;
		end
	end

	assign radix = (radix_cfg_q == '0) ? gscc_pkg::digit_t'(1) : radix_cfg_q;

	always_comb begin
		chain[0].vld  = start && !busy;
		chain[0].rem  = '0;
		chain[0].work = board_index;
		chain[0].dig  = '0;
	end

	for (genvar c = 0; c < gscc_pkg::CHAIN_LEN; c++) begin : g_chain
		gscc_div_cell #(
			.DIGIT (c / gscc_pkg::CELLS_PER_DIGIT),
			.LAST  ((c % gscc_pkg::CELLS_PER_DIGIT) == (gscc_pkg::CELLS_PER_DIGIT - 1))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.radix   (radix),
			.bus_in  (chain[c]),
			.bus_out (chain[c+1])
		);
	end

	gscc_sym_cmp u_cmp (
		.clk          (clk),
		.arst_n       (arst_n),
		.bus_in       (chain[gscc_pkg::CHAIN_LEN]),
		.done         (done),
		.is_canonical (is_canonical),
		.out_of_range (out_of_range)
	);

endmodule

/* rtl/gscc_checker.sv */
// Port-level checker for the grid symmetry canonical check core, with its bind.
// Depends on the assertion macro header.
`include "grid_symmetry_canonical_check_core_assert.svh"

module gscc_checker (
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic done,
	input logic is_canonical,
	input logic out_of_range,
	input logic cfg_ready
);

	// An index outside the nine-digit range can never be reported canonical.
	`GSCC_ASSERT_CLK(a_oor_not_canon,
		done |-> !(is_canonical && out_of_range),
		"out of range item reported canonical")

	// The chain takes an item in every cycle.
	`GSCC_ASSERT_CLK(a_never_busy, !busy, "busy raised")

	// The register port never pushes back.
	`GSCC_ASSERT_CLK(a_cfg_ready, cfg_ready, "configuration write held off")

	// Reset empties the pipeline, so no result shows once it has been seen.
	`GSCC_ASSERT_ALWAYS(a_no_done_in_reset, !arst_n |=> !done, "result during reset")

endmodule

bind grid_symmetry_canonical_check_core gscc_checker u_gscc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.busy         (busy),
	.done         (done),
	.is_canonical (is_canonical),
	.out_of_range (out_of_range),
	.cfg_ready    (cfg_ready)
);
